>>> rtl/core/mef_pkg.sv
// Shared types, constants and the arctangent table of the moment ellipse finaliser.
package mef_pkg;

	localparam int NDIV         = 5;   // dividends sharing one weight
	localparam int W_W          = 47;  // magnitude bits of a positive weight
	localparam int DIV_STEPS    = 64;  // quotient bits, one per stage
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;
	localparam int CORDIC_STEPS = 20;
	localparam int NORM_STEPS   = 6;   // shifts of 32, 16, 8, 4, 2, 1

	// dividend slots
	localparam int IDX_FX = 0;
	localparam int IDX_FY = 1;
	localparam int IDX_XX = 2;
	localparam int IDX_YY = 3;
	localparam int IDX_XY = 4;

	localparam logic [23:0] C_MAX   = 24'hFF_FFFF;
	localparam logic [60:0] MOM_LIM = 61'h1000_0000_0000_0000;
	localparam logic [23:0] DEG90   = 24'd5898240;   // 90 deg, Q.16
	localparam logic [23:0] DEG180  = 24'd11796480;  // 180 deg, Q.16
	localparam logic [15:0] PA_MAX  = 16'd23040;     // 90 deg, Q8.8

	typedef struct packed {
		logic                   ok;
		logic                   last;
		logic [NDIV-1:0]        neg;
		logic [W_W-1:0]         w;
		logic [NDIV-1:0][63:0]  mag;
		logic [23:0]            sx;
		logic [23:0]            sy;
		logic [23:0]            fx;
		logic [23:0]            fy;
	} mef_item_t;

	typedef struct packed {
		logic            ok;
		logic            last;
		logic [NDIV-1:0] neg;
		logic [W_W-1:0]  w;
		logic [23:0]     sx;
		logic [23:0]     sy;
		logic [23:0]     fx;
		logic [23:0]     fy;
	} div_side_t;

	typedef struct packed {
		logic        ok;
		logic        last;
		logic [23:0] cx;
		logic [23:0] cy;
	} tail_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic zero;
	} ang_flag_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// atan(2^-i) in degrees, Q.16
	function automatic logic [25:0] atan_deg(input logic [4:0] i);
		logic [25:0] v;
		unique case (i)
			5'd0:  v = 26'd2949120;
			5'd1:  v = 26'd1740967;
			5'd2:  v = 26'd919879;
			5'd3:  v = 26'd466945;
			5'd4:  v = 26'd234379;
			5'd5:  v = 26'd117304;
			5'd6:  v = 26'd58666;
			5'd7:  v = 26'd29335;
			5'd8:  v = 26'd14668;
			5'd9:  v = 26'd7334;
			5'd10: v = 26'd3667;
			5'd11: v = 26'd1833;
			5'd12: v = 26'd917;
			5'd13: v = 26'd458;
			5'd14: v = 26'd229;
			5'd15: v = 26'd115;
			5'd16: v = 26'd57;
			5'd17: v = 26'd29;
			5'd18: v = 26'd14;
			5'd19: v = 26'd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/mef_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module mef_sqrt #(
	parameter int STEPS = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2*STEPS-1:0]   rad,
	output logic [STEPS-1:0]     root
);

	logic [STEPS+1:0]   rem_s  [1:STEPS];
	logic [STEPS-1:0]   root_s [1:STEPS];
	logic [2*STEPS-1:0] rad_s  [1:STEPS];

	for (genvar k = 1; k <= STEPS; k++) begin : g_stage
		logic [STEPS+1:0]   rem_i;
		logic [STEPS-1:0]   root_i;
		logic [2*STEPS-1:0] rad_i;
		logic [STEPS+3:0]   r2;
		logic [STEPS+3:0]   trial;
		logic               ge;

		if (k == 1) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = rad;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign rad_i  = rad_s[k-1];
		end

		assign r2    = {rem_i, rad_i[2*STEPS-1 -: 2]};
		assign trial = {2'b00, root_i, 2'b01};
		assign ge    = r2 >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (STEPS+2)'(r2 - trial) : r2[STEPS+1:0];
				root_s[k] <= {root_i[STEPS-2:0], ge};
				rad_s[k]  <= {rad_i[2*STEPS-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[STEPS];

endmodule

>>> rtl/core/mef_fifo.sv
// Short queue between the classifying front end and the arithmetic back end.
module mef_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mef_pkg::mef_item_t     push_item,
	input  logic                   pop,
	output mef_pkg::mef_item_t     head,
	output mef_pkg::fifo_stat_t    stat
);

	mef_pkg::mef_item_t           mem_q [0:mef_pkg::FIFO_DEPTH-1];
	logic [mef_pkg::FIFO_AW-1:0]  wr_q;
	logic [mef_pkg::FIFO_AW-1:0]  rd_q;
	logic [mef_pkg::FIFO_AW:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (mef_pkg::FIFO_AW+1)'(push) - (mef_pkg::FIFO_AW+1)'(pop);
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.full  = cnt_q == (mef_pkg::FIFO_AW+1)'(mef_pkg::FIFO_DEPTH);
	assign stat.empty = cnt_q == '0;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue read while empty");

endmodule

>>> rtl/core/mef_front.sv
// Front end: takes input transfers, classifies the weight and splits signs from magnitudes.
module mef_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [47:0]    weight_sum,
	input  logic signed [63:0]    first_x_sum,
	input  logic signed [63:0]    first_y_sum,
	input  logic signed [63:0]    second_xx_sum,
	input  logic signed [63:0]    second_yy_sum,
	input  logic signed [63:0]    second_xy_sum,
	input  logic [23:0]           shift_x,
	input  logic [23:0]           shift_y,
	input  logic [23:0]           fallback_x,
	input  logic [23:0]           fallback_y,
	input  logic                  last_object,
	input  mef_pkg::fifo_stat_t   stat,
	output logic                  push,
	output mef_pkg::mef_item_t    push_item
);

	logic                  vld_q;
	mef_pkg::mef_item_t    item_s1;
	mef_pkg::mef_item_t    item_d;
	logic [mef_pkg::NDIV-1:0][63:0] raw;
	logic                  load;

	assign raw[mef_pkg::IDX_FX] = first_x_sum;
	assign raw[mef_pkg::IDX_FY] = first_y_sum;
	assign raw[mef_pkg::IDX_XX] = second_xx_sum;
	assign raw[mef_pkg::IDX_YY] = second_yy_sum;
	assign raw[mef_pkg::IDX_XY] = second_xy_sum;

	always_comb begin
		item_d.ok   = !weight_sum[47] && (weight_sum != '0);
		item_d.last = last_object;
		item_d.w    = weight_sum[mef_pkg::W_W-1:0];
		item_d.sx   = shift_x;
		item_d.sy   = shift_y;
		item_d.fx   = fallback_x;
		item_d.fy   = fallback_y;
		for (int d = 0; d < mef_pkg::NDIV; d++) begin
			item_d.neg[d] = raw[d][63];
			item_d.mag[d] = raw[d][63] ? (~raw[d] + 64'd1) : raw[d];
		end
	end

	assign push     = vld_q && !stat.full;
	assign load     = !vld_q || !stat.full;
	assign in_stall = vld_q && stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= item_d;
		end
	end

	assign push_item = item_s1;

endmodule

>>> rtl/core/mef_back.sv
// Back end: division, central moments, eigen axes and CORDIC angle, one item per cycle unless stalled.
module mef_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mef_pkg::mef_item_t    head,
	input  mef_pkg::fifo_stat_t   stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [23:0]           centre_x,
	output logic [23:0]           centre_y,
	output logic [23:0]           semi_major_axis,
	output logic [23:0]           semi_minor_axis,
	output logic signed [15:0]    position_angle,
	output logic                  moments_valid,
	output logic                  last_out
);

	localparam int LD    = mef_pkg::DIV_STEPS;
	localparam int S_RND = LD + 1;
	localparam int S_CEN = LD + 2;
	localparam int S_XY  = LD + 5;
	localparam int S_SS  = LD + 8;
	localparam int S_U   = S_SS + 62;
	localparam int S_ARG = S_U + 1;
	localparam int S_AX  = S_ARG + 32;
	localparam int S_OUT = S_AX + 1;
	localparam int S_NRM = S_XY + mef_pkg::NORM_STEPS;
	localparam int S_COR = S_NRM + mef_pkg::CORDIC_STEPS;
	localparam int S_PA  = S_COR + 1;
	localparam int N_SUM = S_U - S_XY;
	localparam int N_PA  = S_AX - S_PA;
	localparam int N_TL  = S_AX - S_CEN;

	logic adv;
	logic vld_q [1:S_OUT];

	assign adv = !(vld_q[S_OUT] && out_stall);
	assign pop = adv && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_OUT; k++) vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[1] <= pop;
			for (int k = 2; k <= S_OUT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// restoring division, five dividends over one weight
	logic [mef_pkg::W_W-1:0] dr_s  [1:LD][0:mef_pkg::NDIV-1];
	logic [63:0]             dn_s  [1:LD][0:mef_pkg::NDIV-1];
	mef_pkg::div_side_t      dsd_s [1:LD];

	for (genvar k = 1; k <= LD; k++) begin : g_div
		logic [mef_pkg::W_W-1:0] rem_i [0:mef_pkg::NDIV-1];
		logic [63:0]             num_i [0:mef_pkg::NDIV-1];
		mef_pkg::div_side_t      sd_i;
		logic [mef_pkg::W_W:0]   r2    [0:mef_pkg::NDIV-1];
		logic [mef_pkg::NDIV-1:0] ge;

		if (k == 1) begin : g_first
			always_comb begin
				for (int d = 0; d < mef_pkg::NDIV; d++) begin
					rem_i[d] = '0;
					num_i[d] = head.mag[d];
				end
			end
			assign sd_i = '{ok: head.ok, last: head.last, neg: head.neg, w: head.w,
				sx: head.sx, sy: head.sy, fx: head.fx, fy: head.fy};
		end else begin : g_next
			always_comb begin
				for (int d = 0; d < mef_pkg::NDIV; d++) begin
					rem_i[d] = dr_s[k-1][d];
					num_i[d] = dn_s[k-1][d];
				end
			end
			assign sd_i = dsd_s[k-1];
		end

		always_comb begin
			for (int d = 0; d < mef_pkg::NDIV; d++) begin
				r2[d] = {rem_i[d], num_i[d][63]};
				ge[d] = r2[d] >= {1'b0, sd_i.w};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dsd_s[k] <= sd_i;
				for (int d = 0; d < mef_pkg::NDIV; d++) begin
					dr_s[k][d] <= ge[d] ? mef_pkg::W_W'(r2[d] - {1'b0, sd_i.w})
						: r2[d][mef_pkg::W_W-1:0];
					dn_s[k][d] <= {num_i[d][62:0], ge[d]};
				end
			end
		end
	end

	// round to nearest, ties away from zero
	logic [63:0]        rq_s65 [0:mef_pkg::NDIV-1];
	mef_pkg::div_side_t sd_s65;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s65 <= dsd_s[LD];
			for (int d = 0; d < mef_pkg::NDIV; d++) begin
				rq_s65[d] <= dn_s[LD][d]
					+ 64'({dr_s[LD][d], 1'b0} >= {1'b0, dsd_s[LD].w});
			end
		end
	end

	// centroid saturation, offsets from shift point, saturated shifted quotients
	logic [23:0]        cq_x, cq_y;
	logic [60:0]        qm [mef_pkg::IDX_XX:mef_pkg::IDX_XY];
	logic signed [24:0] dx_s66, dy_s66;
	logic signed [61:0] q_s66 [mef_pkg::IDX_XX:mef_pkg::IDX_XY];
	mef_pkg::tail_t     tl_s66;

	always_comb begin
		cq_x = sd_s65.neg[mef_pkg::IDX_FX] ? 24'd0
			: (rq_s65[mef_pkg::IDX_FX] > 64'(mef_pkg::C_MAX) ? mef_pkg::C_MAX
			: rq_s65[mef_pkg::IDX_FX][23:0]);
		cq_y = sd_s65.neg[mef_pkg::IDX_FY] ? 24'd0
			: (rq_s65[mef_pkg::IDX_FY] > 64'(mef_pkg::C_MAX) ? mef_pkg::C_MAX
			: rq_s65[mef_pkg::IDX_FY][23:0]);
		for (int d = mef_pkg::IDX_XX; d <= mef_pkg::IDX_XY; d++) begin
			qm[d] = rq_s65[d] > 64'(mef_pkg::MOM_LIM) ? mef_pkg::MOM_LIM : rq_s65[d][60:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s66    <= $signed({1'b0, cq_x}) - $signed({1'b0, sd_s65.sx});
			dy_s66    <= $signed({1'b0, cq_y}) - $signed({1'b0, sd_s65.sy});
			tl_s66.ok   <= sd_s65.ok;
			tl_s66.last <= sd_s65.last;
			tl_s66.cx   <= sd_s65.ok ? cq_x : sd_s65.fx;
			tl_s66.cy   <= sd_s65.ok ? cq_y : sd_s65.fy;
			for (int d = mef_pkg::IDX_XX; d <= mef_pkg::IDX_XY; d++) begin
				q_s66[d] <= sd_s65.neg[d] ? -$signed({1'b0, qm[d]}) : $signed({1'b0, qm[d]});
			end
		end
	end

	// offset products
	logic signed [49:0] p_s67 [mef_pkg::IDX_XX:mef_pkg::IDX_XY];
	logic signed [61:0] q_s67 [mef_pkg::IDX_XX:mef_pkg::IDX_XY];

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s67[mef_pkg::IDX_XX] <= dx_s66 * dx_s66;
			p_s67[mef_pkg::IDX_YY] <= dy_s66 * dy_s66;
			p_s67[mef_pkg::IDX_XY] <= dx_s66 * dy_s66;
			for (int d = mef_pkg::IDX_XX; d <= mef_pkg::IDX_XY; d++) q_s67[d] <= q_s66[d];
		end
	end

	// central moments, saturated
	logic signed [62:0] mdiff [mef_pkg::IDX_XX:mef_pkg::IDX_XY];
	logic signed [61:0] m_s68 [mef_pkg::IDX_XX:mef_pkg::IDX_XY];
	logic signed [62:0] lim_p, lim_n;

	assign lim_p = $signed({2'b00, mef_pkg::MOM_LIM});
	assign lim_n = -lim_p;

	always_comb begin
		for (int d = mef_pkg::IDX_XX; d <= mef_pkg::IDX_XY; d++) begin
			mdiff[d] = 63'(q_s67[d]) - 63'(p_s67[d]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = mef_pkg::IDX_XX; d <= mef_pkg::IDX_XY; d++) begin
				if (mdiff[d] > lim_p)      m_s68[d] <= 62'(lim_p);
				else if (mdiff[d] < lim_n) m_s68[d] <= 62'(lim_n);
				else                       m_s68[d] <= 62'(mdiff[d]);
			end
		end
	end

	// difference, doubled cross term, trace
	logic signed [62:0] xd, yd;
	logic [61:0]        ax_s69, ay_s69;
	logic signed [62:0] sum_s69;
	mef_pkg::ang_flag_t fl_s69;

	assign xd = 63'(m_s68[mef_pkg::IDX_XX]) - 63'(m_s68[mef_pkg::IDX_YY]);
	assign yd = {m_s68[mef_pkg::IDX_XY], 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s69       <= xd[62] ? 62'(-xd) : xd[61:0];
			ay_s69       <= yd[62] ? 62'(-yd) : yd[61:0];
			sum_s69      <= 63'(m_s68[mef_pkg::IDX_XX]) + 63'(m_s68[mef_pkg::IDX_YY]);
			fl_s69.neg_x <= xd[62];
			fl_s69.neg_y <= yd[62];
			fl_s69.zero  <= (xd == '0) && (yd == '0);
		end
	end

	// squares as 31-bit partial products
	logic [61:0] pxh_s70, pxm_s70, pxl_s70, pyh_s70, pym_s70, pyl_s70;
	always_ff @(posedge clk) begin
		if (adv) begin
			pxh_s70 <= ax_s69[61:31] * ax_s69[61:31];
			pxm_s70 <= ax_s69[61:31] * {1'b0, ax_s69[30:0]};
			pxl_s70 <= {1'b0, ax_s69[30:0]} * {1'b0, ax_s69[30:0]};
			pyh_s70 <= ay_s69[61:31] * ay_s69[61:31];
			pym_s70 <= ay_s69[61:31] * {1'b0, ay_s69[30:0]};
			pyl_s70 <= {1'b0, ay_s69[30:0]} * {1'b0, ay_s69[30:0]};
		end
	end

	logic [123:0] sqx_s71, sqy_s71, ss_s72;
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s71 <= {pxh_s70, 62'd0} + {30'd0, pxm_s70, 32'd0} + {62'd0, pxl_s70};
			sqy_s71 <= {pyh_s70, 62'd0} + {30'd0, pym_s70, 32'd0} + {62'd0, pyl_s70};
			ss_s72  <= sqx_s71 + sqy_s71;
		end
	end

	logic [61:0] u_root;
	mef_sqrt #(.STEPS(62)) u_sqrt_hyp (
		.clk  (clk),
		.en   (adv),
		.rad  (ss_s72),
		.root (u_root)
	);

	// trace delayed to meet the root
	logic signed [62:0] sum_d [1:N_SUM];
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_d[1] <= sum_s69;
			for (int k = 2; k <= N_SUM; k++) sum_d[k] <= sum_d[k-1];
		end
	end

	logic signed [63:0] argp, argm;
	logic [63:0]        radp_s135, radm_s135;
	assign argp = 64'(sum_d[N_SUM]) + $signed({2'b00, u_root});
	assign argm = 64'(sum_d[N_SUM]) - $signed({2'b00, u_root});

	always_ff @(posedge clk) begin
		if (adv) begin
			radp_s135 <= (!argp[63] && argp != '0) ? {argp[62:0], 1'b0} : 64'd0;
			radm_s135 <= (!argm[63] && argm != '0) ? {argm[62:0], 1'b0} : 64'd0;
		end
	end

	logic [31:0] vmaj, vmin;
	mef_sqrt #(.STEPS(32)) u_sqrt_maj (
		.clk  (clk),
		.en   (adv),
		.rad  (radp_s135),
		.root (vmaj)
	);
	mef_sqrt #(.STEPS(32)) u_sqrt_min (
		.clk  (clk),
		.en   (adv),
		.rad  (radm_s135),
		.root (vmin)
	);

	// angle: normalise so the larger magnitude tops bit 61
	logic [61:0]        nax_s [0:mef_pkg::NORM_STEPS-1];
	logic [61:0]        nay_s [0:mef_pkg::NORM_STEPS-1];
	logic [61:0]        nm_s  [0:mef_pkg::NORM_STEPS-1];
	mef_pkg::ang_flag_t nfl_s [0:mef_pkg::NORM_STEPS-1];

	for (genvar j = 0; j < mef_pkg::NORM_STEPS; j++) begin : g_norm
		localparam int K = 32 >> j;
		logic [61:0]        ax_i, ay_i, m_i;
		mef_pkg::ang_flag_t fl_i;
		logic               sh;

		if (j == 0) begin : g_first
			assign ax_i = ax_s69;
			assign ay_i = ay_s69;
			assign m_i  = (ax_s69 > ay_s69) ? ax_s69 : ay_s69;
			assign fl_i = fl_s69;
		end else begin : g_next
			assign ax_i = nax_s[j-1];
			assign ay_i = nay_s[j-1];
			assign m_i  = nm_s[j-1];
			assign fl_i = nfl_s[j-1];
		end

		assign sh = m_i[61 -: K] == '0;

		always_ff @(posedge clk) begin
			if (adv) begin
				nax_s[j] <= sh ? (ax_i << K) : ax_i;
				nay_s[j] <= sh ? (ay_i << K) : ay_i;
				nm_s[j]  <= sh ? (m_i << K) : m_i;
				nfl_s[j] <= fl_i;
			end
		end
	end

	// CORDIC vectoring, degrees Q.16
	logic signed [33:0] cx_s  [0:mef_pkg::CORDIC_STEPS-1];
	logic signed [33:0] cy_s  [0:mef_pkg::CORDIC_STEPS-1];
	logic signed [25:0] cz_s  [0:mef_pkg::CORDIC_STEPS-1];
	mef_pkg::ang_flag_t cfl_s [0:mef_pkg::CORDIC_STEPS-1];

	for (genvar i = 0; i < mef_pkg::CORDIC_STEPS; i++) begin : g_cordic
		logic signed [33:0] x_i, y_i;
		logic signed [25:0] z_i;
		mef_pkg::ang_flag_t fl_i;
		logic signed [25:0] at;

		if (i == 0) begin : g_first
			assign x_i  = $signed({4'd0, nax_s[mef_pkg::NORM_STEPS-1][61:32]});
			assign y_i  = $signed({4'd0, nay_s[mef_pkg::NORM_STEPS-1][61:32]});
			assign z_i  = '0;
			assign fl_i = nfl_s[mef_pkg::NORM_STEPS-1];
		end else begin : g_next
			assign x_i  = cx_s[i-1];
			assign y_i  = cy_s[i-1];
			assign z_i  = cz_s[i-1];
			assign fl_i = cfl_s[i-1];
		end

		assign at = $signed(mef_pkg::atan_deg(5'(i)));

		always_ff @(posedge clk) begin
			if (adv) begin
				cfl_s[i] <= fl_i;
				if (!y_i[33]) begin
					cx_s[i] <= x_i + (y_i >>> i);
					cy_s[i] <= y_i - (x_i >>> i);
					cz_s[i] <= z_i + at;
				end else begin
					cx_s[i] <= x_i - (y_i >>> i);
					cy_s[i] <= y_i + (x_i >>> i);
					cz_s[i] <= z_i - at;
				end
			end
		end
	end

	// quadrant fix, halve and round to Q8.8
	logic signed [25:0] zf;
	mef_pkg::ang_flag_t af;
	logic [23:0]        tc, tq;
	logic [24:0]        tr;
	logic [15:0]        pm;
	logic signed [15:0] pa_s96;

	assign zf = cz_s[mef_pkg::CORDIC_STEPS-1];
	assign af = cfl_s[mef_pkg::CORDIC_STEPS-1];

	always_comb begin
		if (zf[25])                             tc = '0;
		else if (zf > $signed(26'(mef_pkg::DEG90))) tc = mef_pkg::DEG90;
		else                                    tc = zf[23:0];
		tq = af.neg_x ? (mef_pkg::DEG180 - tc) : tc;
		tr = ({1'b0, tq} + 25'd256) >> 9;
		pm = (tr > 25'(mef_pkg::PA_MAX)) ? mef_pkg::PA_MAX : tr[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (af.zero)       pa_s96 <= '0;
			else if (af.neg_y) pa_s96 <= -$signed(pm);
			else               pa_s96 <= $signed(pm);
		end
	end

	logic signed [15:0] pa_d [1:N_PA];
	mef_pkg::tail_t     tl_d [1:N_TL];
	always_ff @(posedge clk) begin
		if (adv) begin
			pa_d[1] <= pa_s96;
			for (int k = 2; k <= N_PA; k++) pa_d[k] <= pa_d[k-1];
			tl_d[1] <= tl_s66;
			for (int k = 2; k <= N_TL; k++) tl_d[k] <= tl_d[k-1];
		end
	end

	// axis rounding and output register
	logic [32:0] hmaj, hmin;
	assign hmaj = ({1'b0, vmaj} + 33'd1) >> 1;
	assign hmin = ({1'b0, vmin} + 33'd1) >> 1;

	always_ff @(posedge clk) begin
		if (adv) begin
			centre_x        <= tl_d[N_TL].cx;
			centre_y        <= tl_d[N_TL].cy;
			moments_valid   <= tl_d[N_TL].ok;
			last_out        <= tl_d[N_TL].last;
			semi_major_axis <= !tl_d[N_TL].ok ? 24'd0
				: (hmaj > 33'(mef_pkg::C_MAX) ? mef_pkg::C_MAX : hmaj[23:0]);
			semi_minor_axis <= !tl_d[N_TL].ok ? 24'd0
				: (hmin > 33'(mef_pkg::C_MAX) ? mef_pkg::C_MAX : hmin[23:0]);
			position_angle  <= tl_d[N_TL].ok ? pa_d[N_PA] : 16'sd0;
		end
	end

	assign out_valid = vld_q[S_OUT];

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !moments_valid |->
			semi_major_axis == '0 && semi_minor_axis == '0 && position_angle == '0)
		else $error("moments flagged invalid but shape not cleared");
	a_axis_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> semi_minor_axis <= semi_major_axis)
		else $error("minor axis exceeds major axis");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> position_angle <= $signed(mef_pkg::PA_MAX)
			&& position_angle >= -$signed(mef_pkg::PA_MAX))
		else $error("position angle out of range");

endmodule

>>> rtl/core/moment_ellipse_finalizer.sv
// Top level of the moment ellipse finaliser: front end, queue and arithmetic back end.
//
// Input channel: in_valid / in_stall carry one object's raw sums per transfer;
// a transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result per input transfer,
// in input order: centroid, semi-axes, position angle, moments_valid, last_out.
// Throughput: one transfer per cycle, sustained, while out_stall stays low.
// The pipeline from input transfer to the result on the ports is mostly the
// 64-stage bit-per-stage divider, the 62-stage root of the eigenvalue spread
// and the 32-stage axis roots; the 20-step CORDIC angle runs alongside the
// root.
// A weight that is not positive gives the fallback centre, zero axes, zero
// angle and moments_valid low.
// Reset (arst_n low, asynchronous) empties the front register, the 4-entry
// queue and every valid bit of the back-end pipeline; data registers keep
// whatever they held.
// While out_stall holds a result, the whole back end freezes; the queue and
// front register keep taking transfers until full, then in_stall rises.
module moment_ellipse_finalizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [47:0]  weight_sum,
	input  logic signed [63:0]  first_x_sum,
	input  logic signed [63:0]  first_y_sum,
	input  logic signed [63:0]  second_xx_sum,
	input  logic signed [63:0]  second_yy_sum,
	input  logic signed [63:0]  second_xy_sum,
	input  logic [23:0]         shift_x,
	input  logic [23:0]         shift_y,
	input  logic [23:0]         fallback_x,
	input  logic [23:0]         fallback_y,
	input  logic                last_object,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [23:0]         centre_x,
	output logic [23:0]         centre_y,
	output logic [23:0]         semi_major_axis,
	output logic [23:0]         semi_minor_axis,
	output logic signed [15:0]  position_angle,
	output logic                moments_valid,
	output logic                last_out
);

	// front end to queue
	logic                  push;
	mef_pkg::mef_item_t    push_item;
	// queue to back end
	logic                  pop;
	mef_pkg::mef_item_t    head;
	mef_pkg::fifo_stat_t   stat;

	mef_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.weight_sum    (weight_sum),
		.first_x_sum   (first_x_sum),
		.first_y_sum   (first_y_sum),
		.second_xx_sum (second_xx_sum),
		.second_yy_sum (second_yy_sum),
		.second_xy_sum (second_xy_sum),
		.shift_x       (shift_x),
		.shift_y       (shift_y),
		.fallback_x    (fallback_x),
		.fallback_y    (fallback_y),
		.last_object   (last_object),
		.stat          (stat),
		.push          (push),
		.push_item     (push_item)
	);

	// decouples the two halves so each can stall on its own
	mef_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	mef_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.stat            (stat),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.centre_x        (centre_x),
		.centre_y        (centre_y),
		.semi_major_axis (semi_major_axis),
		.semi_minor_axis (semi_minor_axis),
		.position_angle  (position_angle),
		.moments_valid   (moments_valid),
		.last_out        (last_out)
	);

endmodule
